FILE: design/rlld_pkg.sv
// Shared constants, types and tables of the reed ladder level decoder.
`timescale 1ns / 1ps
package rlld_pkg;

    localparam int WINDOW_DEPTH     = 128;
    localparam int LINE_COUNT       = 2;
    localparam int SAMPLE_BITS      = 12;
    localparam int SENSORS_PER_LINE = 6;

    localparam int NUM_THRESH = 7;
    localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
    localparam int POS_W      = $clog2(NUM_THRESH + 1);
    localparam int LEVEL_W    = 11;
    localparam int IDX_W      = $clog2(NUM_THRESH);

    localparam int LEVEL_SPAN    = 900;
    localparam int LINE_OFFSET_A = 0;
    localparam int LINE_OFFSET_B = 100;

    localparam bit LINE_B_EN = (LINE_COUNT > 1);

    localparam int REG_THRESH_BASE = 0;

    typedef logic [NUM_THRESH-1:0][SUM_W-1:0] thresh_t;
    typedef logic [(1 << POS_W)-1:0][LEVEL_W-1:0] level_tab_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] a;
        logic [SAMPLE_BITS-1:0] b;
    } pair_t;

    typedef struct packed {
        logic [SUM_W-1:0]   sum_a;
        logic [SUM_W-1:0]   sum_b;
        logic [POS_W-1:0]   pos_a;
        logic [POS_W-1:0]   pos_b;
        logic               trig;
        logic [LEVEL_W-1:0] level;
    } result_t;

    localparam thresh_t THRESH_RESET = {
        SUM_W'(470245), SUM_W'(378208), SUM_W'(300523), SUM_W'(231511),
        SUM_W'(166955), SUM_W'(103146), SUM_W'(36173)
    };

    function automatic level_tab_t build_level_tab(input int offset);
        level_tab_t tab;
        for (int k = 0; k < (1 << POS_W); k++) begin
            tab[k] = LEVEL_W'((k * LEVEL_SPAN) / SENSORS_PER_LINE + offset);
        end
        return tab;
    endfunction

    localparam level_tab_t LEVEL_TAB_A = build_level_tab(LINE_OFFSET_A);
    localparam level_tab_t LEVEL_TAB_B = build_level_tab(LINE_OFFSET_B);

endpackage

FILE: design/rlld_cell.sv
// One history cell: holds one sample of each line and passes it on per item.
`timescale 1ns / 1ps
module rlld_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           shift_en,
    input  rlld_pkg::pair_t din,
    output rlld_pkg::pair_t dout
);
    import rlld_pkg::*;

    pair_t sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (shift_en) begin
            sample_reg <= din;
        end
    end

    assign dout = sample_reg;

endmodule

FILE: design/rlld_decode.sv
// Threshold decode, held positions, level mean and result register.
`timescale 1ns / 1ps
module rlld_decode (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  logic [rlld_pkg::SUM_W-1:0]  sum_a,
    input  logic [rlld_pkg::SUM_W-1:0]  sum_b,
    input  rlld_pkg::thresh_t           thresh,
    output rlld_pkg::result_t           res
);
    import rlld_pkg::*;

    logic [POS_W-1:0]   fresh_a;
    logic [POS_W-1:0]   fresh_b;
    logic               trig;
    logic [POS_W-1:0]   held_a_reg, held_a_next;
    logic [POS_W-1:0]   held_b_reg, held_b_next;
    logic [LEVEL_W-1:0] lvl_a;
    logic [LEVEL_W-1:0] lvl_b;
    logic [LEVEL_W:0]   lvl_sum;
    logic [LEVEL_W-1:0] level;
    result_t            res_reg, res_next;

    always_comb begin
        fresh_a = '0;
        fresh_b = '0;
        for (int k = 0; k < NUM_THRESH; k++) begin
            if (sum_a >= thresh[k]) fresh_a = fresh_a + POS_W'(1);
            if (sum_b >= thresh[k]) fresh_b = fresh_b + POS_W'(1);
        end
        if (!LINE_B_EN) fresh_b = '0;
    end

    assign trig        = (fresh_a != '0) || (fresh_b != '0);
    assign held_a_next = trig ? fresh_a : held_a_reg;
    assign held_b_next = trig ? fresh_b : held_b_reg;

    assign lvl_a   = (held_a_next != '0) ? LEVEL_TAB_A[held_a_next] : '0;
    assign lvl_b   = (held_b_next != '0) ? LEVEL_TAB_B[held_b_next] : '0;
    assign lvl_sum = {1'b0, lvl_a} + {1'b0, lvl_b};

    // mean of two is a halving; with one line live the sum is that line
    assign level = ((held_a_next != '0) && (held_b_next != '0)) ?
                   lvl_sum[LEVEL_W:1] : lvl_sum[LEVEL_W-1:0];

    always_comb begin
        res_next       = res_reg;
        res_next.sum_a = sum_a;
        res_next.sum_b = sum_b;
        res_next.pos_a = held_a_next;
        res_next.pos_b = held_b_next;
        res_next.trig  = trig;
        res_next.level = level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_a_reg <= '0;
            held_b_reg <= '0;
        end else if (load) begin
            held_a_reg <= held_a_next;
            held_b_reg <= held_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: design/reed_ladder_level_decoder_unit.sv
// Top level of the reed ladder level decoder: history chain, sums, decode, handshake.
`timescale 1ns / 1ps
// Takes one item (one sample per sensor line) per clock when the output side keeps
// up and returns one result per item, registered in the window sums and then in the
// result register. The history is a chain of 128 cells that advances once per
// accepted item; the sample leaving its tail is subtracted from each running window
// sum in the same cycle the new sample is added. The second stage compares each sum
// with the seven thresholds, updates the held positions and forms the level.
// Thresholds are written through cfg_wr_en/cfg_index/cfg_wdata while idle;
// indexes beyond the seventh threshold are ignored.
module reed_ladder_level_decoder_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [rlld_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rlld_pkg::SUM_W-1:0]    cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rlld_pkg::SAMPLE_BITS-1:0] s_sample_a,
    input  logic [rlld_pkg::SAMPLE_BITS-1:0] s_sample_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rlld_pkg::SUM_W-1:0]    m_window_sum_a,
    output logic [rlld_pkg::SUM_W-1:0]    m_window_sum_b,
    output logic [rlld_pkg::POS_W-1:0]    m_position_a,
    output logic [rlld_pkg::POS_W-1:0]    m_position_b,
    output logic                          m_triggered,
    output logic [rlld_pkg::LEVEL_W-1:0]  m_water_level
);
    import rlld_pkg::*;

    thresh_t thresh_reg, thresh_next;

    pair_t cell_in  [WINDOW_DEPTH];
    pair_t cell_out [WINDOW_DEPTH];
    pair_t new_pair;
    pair_t tail;

    logic [SUM_W-1:0] sum_a_reg, sum_a_next;
    logic [SUM_W-1:0] sum_b_reg, sum_b_next;
    logic             p1_valid_reg, p1_valid_next;
    logic             m_valid_reg, m_valid_next;
    logic             accept;
    logic             out_free;
    logic             load2;
    result_t          res;

    // config
    always_comb begin
        thresh_next = thresh_reg;
        for (int k = 0; k < NUM_THRESH; k++) begin
            if (cfg_wr_en && (cfg_index == IDX_W'(REG_THRESH_BASE + k))) begin
                thresh_next[k] = cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= THRESH_RESET;
        end else begin
            thresh_reg <= thresh_next;
        end
    end

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !p1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;
    assign load2    = p1_valid_reg && out_free;

    assign p1_valid_next = accept ? 1'b1 : (load2 ? 1'b0 : p1_valid_reg);
    assign m_valid_next  = load2 ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // history chain
    assign new_pair.a = s_sample_a;
    assign new_pair.b = LINE_B_EN ? s_sample_b : '0;

    genvar g;
    generate
        for (g = 0; g < WINDOW_DEPTH; g++) begin : g_chain
            if (g == 0) begin : g_head
                assign cell_in[g] = new_pair;
            end else begin : g_link
                assign cell_in[g] = cell_out[g-1];
            end
            rlld_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (accept),
                .din      (cell_in[g]),
                .dout     (cell_out[g])
            );
        end
    endgenerate

    assign tail = cell_out[WINDOW_DEPTH-1];

    // window sums
    assign sum_a_next = sum_a_reg + SUM_W'(new_pair.a) - SUM_W'(tail.a);
    assign sum_b_next = sum_b_reg + SUM_W'(new_pair.b) - SUM_W'(tail.b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end else if (accept) begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    rlld_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load2),
        .sum_a   (sum_a_reg),
        .sum_b   (sum_b_reg),
        .thresh  (thresh_reg),
        .res     (res)
    );

    assign m_valid        = m_valid_reg;
    assign m_window_sum_a = res.sum_a;
    assign m_window_sum_b = res.sum_b;
    assign m_position_a   = res.pos_a;
    assign m_position_b   = res.pos_b;
    assign m_triggered    = res.trig;
    assign m_water_level  = res.level;

    a_trig_pos : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_triggered) |-> (m_position_a != '0 || m_position_b != '0))
        else $error("triggered item reports no position");

    a_level_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_position_a == '0 && m_position_b == '0) |-> (m_water_level == '0))
        else $error("level nonzero with no position");

    a_stage_moves : assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !m_valid_reg) |=> m_valid)
        else $error("first stage item did not reach the output register");

endmodule
